>>> rtl/sfdd_pkg.sv
// Shared types, constants and register indexes for the stereo feedback delay.
// No dependencies.
package sfdd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_TIME    = 3'd0,
        REG_FEEDBACK_GAIN = 3'd1,
        REG_TONE_COEFF    = 3'd2,
        REG_WET_MIX       = 3'd3,
        REG_DUCK_DEPTH    = 3'd4,
        REG_DUCK_SENS     = 3'd5,
        REG_ATTACK_COEFF  = 3'd6,
        REG_RELEASE_COEFF = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ0,
        ST_READ1,
        ST_INTERP,
        ST_TONE,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic rd0;
        logic rd1;
        logic interp;
        logic tone;
        logic wr;
        logic mix;
    } t_lane_ctl;

endpackage

>>> rtl/sfdd_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sfdd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/sfdd_lane.sv
// One channel lane: delay line read with interpolation, tone filter, write-back, mix.
// Depends on sfdd_pkg and sfdd_ram.
module sfdd_lane import sfdd_pkg::*; #(
    parameter int LINE_DEPTH  = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic                          i_clr,
    input  logic [$clog2(LINE_DEPTH)-1:0] i_clr_addr,
    input  logic [$clog2(LINE_DEPTH)-1:0] i_addr0,
    input  logic [$clog2(LINE_DEPTH)-1:0] i_addr1,
    input  logic [$clog2(LINE_DEPTH)-1:0] i_waddr,
    input  logic [7:0]                    i_frac,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic [15:0]                   i_tone_coeff,
    input  logic [15:0]                   i_feedback,
    input  logic [16:0]                   i_dry_gain,
    input  logic [16:0]                   i_wet_gain,
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam logic signed [SB+1:0] SMAX = (SB+2)'((64'sd1 <<< (SB-1)) - 1);
    localparam logic signed [SB+1:0] SMIN = -SMAX - 1;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [SB-1:0] ram_wdata, ram_rdata;

    logic signed [SB-1:0] r_s0, n_s0;
    logic signed [SB-1:0] r_dly, n_dly;
    logic signed [SB+1:0] r_tone, n_tone;
    logic signed [SB-1:0] r_y, n_y;

    logic signed [SB+9:0]  interp_sum;
    logic signed [SB+2:0]  tone_diff;
    logic signed [SB+19:0] tone_prod;
    logic signed [SB+18:0] fb_prod;
    logic signed [SB+3:0]  fb_sum;
    logic signed [SB+18:0] mix_sum;
    logic signed [SB+2:0]  mix_rnd;
    logic signed [SB+1:0]  tone_new;

    sfdd_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    function automatic logic signed [SB-1:0] sat_s(input logic signed [SB+3:0] v);
        if (v > SB'(SMAX) && v > (SB+4)'(SMAX)) begin
            return SMAX[SB-1:0];
        end else if (v < (SB+4)'(SMIN)) begin
            return SMIN[SB-1:0];
        end
        return v[SB-1:0];
    endfunction

    always_comb begin
        ram_we    = i_clr | i_ctl.wr;
        ram_addr  = i_clr ? i_clr_addr : (i_ctl.wr ? i_waddr : (i_ctl.rd1 ? i_addr1 : i_addr0));
        interp_sum = (SB+10)'(r_s0) * $signed({2'b0, 9'd256 - {1'b0, i_frac}})
                   + (SB+10)'($signed(ram_rdata)) * $signed({3'b0, i_frac});
        tone_diff = (SB+3)'(r_tone) - (SB+3)'(r_dly);
        tone_prod = tone_diff * $signed({1'b0, i_tone_coeff}) + (SB+20)'(32768);
        tone_new  = (SB+2)'(r_dly) + (SB+2)'(tone_prod >>> 16);
        fb_prod   = r_tone * $signed({1'b0, i_feedback}) + (SB+19)'(32768);
        fb_sum    = (SB+4)'(i_x) + (SB+4)'(fb_prod >>> 16);
        ram_wdata = i_clr ? '0 : sat_s(fb_sum);
        mix_sum   = (SB+19)'(i_x) * $signed({1'b0, i_dry_gain})
                  + (SB+19)'(r_dly) * $signed({1'b0, i_wet_gain}) + (SB+19)'(32768);
        mix_rnd   = (SB+3)'(mix_sum >>> 16);

        n_s0   = r_s0;
        n_dly  = r_dly;
        n_tone = r_tone;
        n_y    = r_y;
        if (i_ctl.rd1) begin
            n_s0 = $signed(ram_rdata);
        end
        if (i_ctl.interp) begin
            n_dly = SB'((interp_sum + (SB+10)'(128)) >>> 8);
        end
        if (i_ctl.tone) begin
            n_tone = tone_new;
        end
        if (i_ctl.mix) begin
            n_y = sat_s((SB+4)'(mix_rnd));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone <= '0;
        end else begin
            r_tone <= n_tone;
        end
        r_s0  <= n_s0;
        r_dly <= n_dly;
        r_y   <= n_y;
    end

    assign o_y = r_y;
endmodule

>>> rtl/sfdd_env.sv
// Envelope follower on the left input and ducked wet gain (merging stage).
// Depends on sfdd_pkg.
module sfdd_env import sfdd_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_peak,
    input  logic                          i_lvl,
    input  logic                          i_gain,
    input  logic                          i_wetg,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic [15:0]                   i_sens,
    input  logic [23:0]                   i_attack,
    input  logic [23:0]                   i_release,
    input  logic [16:0]                   i_depth,
    input  logic [16:0]                   i_mix,
    output logic [16:0]                   o_wet_gain
);
    localparam int SB = SAMPLE_BITS;
    localparam int LW = SB + 2;
    localparam logic [LW-1:0] ONE = LW'(1) << (SB-1);

    logic [LW-1:0] r_peak, n_peak;
    logic [LW-1:0] r_lvl, n_lvl;
    logic [16:0]   r_gain, n_gain;
    logic [16:0]   r_wetg, n_wetg;

    logic [SB-1:0]        mag;
    logic [SB+16:0]       peak_prod;
    logic [23:0]          k;
    logic signed [LW:0]   diff;
    logic signed [LW+25:0] lvl_prod;
    logic [LW-1:0]        envc;
    logic [SB+16:0]       dep_prod;
    logic [33:0]          wet_prod;

    always_comb begin
        mag       = i_x[SB-1] ? SB'(-i_x) : SB'(i_x);
        peak_prod = (SB+17)'(mag) * (SB+17)'(i_sens) + (SB+17)'(8192);
        k         = (r_peak > r_lvl) ? i_attack : i_release;
        diff      = $signed({1'b0, r_lvl}) - $signed({1'b0, r_peak});
        lvl_prod  = (LW+26)'(diff) * $signed({1'b0, k}) + (LW+26)'(1 << 23);
        envc      = (r_lvl > ONE) ? ONE : r_lvl;
        dep_prod  = (SB+17)'(i_depth) * (SB+17)'(envc) + (SB+17)'(ONE >> 1);
        wet_prod  = 34'(i_mix) * 34'(r_gain) + 34'(32768);

        n_peak = r_peak;
        n_lvl  = r_lvl;
        n_gain = r_gain;
        n_wetg = r_wetg;
        if (i_peak) begin
            n_peak = LW'(peak_prod >> 14);
        end
        if (i_lvl) begin
            n_lvl = LW'($signed({1'b0, r_peak}) + (LW+1)'(lvl_prod >>> 24));
        end
        if (i_gain) begin
            n_gain = 17'(18'd65536 - 18'(dep_prod >> (SB-1)));
        end
        if (i_wetg) begin
            n_wetg = 17'(wet_prod >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else begin
            r_lvl <= n_lvl;
        end
        r_peak <= n_peak;
        r_gain <= n_gain;
        r_wetg <= n_wetg;
    end

    assign o_wet_gain = r_wetg;
endmodule

>>> rtl/stereo_feedback_delay_ducking_unit.sv
// Top level of the stereo feedback delay with ducking: control, two lanes, envelope.
// Depends on sfdd_pkg, sfdd_lane, sfdd_env.
//
// channel  dir  fields (low bit first)
// s_axis   in   left_in[23:0], right_in[47:24]
// m_axis   out  left_out[23:0], right_out[47:24]
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// A frame runs from transfer in to the earliest result transfer through two RAM
// reads, interpolation, tone filter, write-back with mix, output load, output.
// After reset a clearing pass zeroes all LINE_DEPTH entries of both delay lines.
// The next frame is taken while a result waits in the output register; a stalled
// result holds the following frame in ST_OUT.
module stereo_feedback_delay_ducking_unit import sfdd_pkg::*; #(
    parameter int LINE_DEPTH  = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [2*SAMPLE_BITS-1:0] s_axis_tdata,   // left_in, right_in
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [2*SAMPLE_BITS-1:0] m_axis_tdata,   // left_out, right_out
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam int PW = AW + 8;

    t_state r_state, n_state;
    logic [24:0] r_delay;
    logic [15:0] r_fb, r_tone_c, r_sens;
    logic [16:0] r_mix, r_depth;
    logic [23:0] r_att, r_rel;
    logic [AW-1:0] r_widx;
    logic          r_clr;
    logic [AW:0]   r_clr_cnt;
    logic [2*SB-1:0] r_x;
    logic [2*SB-1:0] r_out;
    logic            r_out_v;

    t_lane_ctl ctl;
    logic      accept, out_load;
    logic [PW-1:0] pos;
    logic [AW-1:0] a0, a1;
    logic [16:0]   mix_c, dep_c, dry_g, wet_g;
    logic signed [SB-1:0] yl, yr;

    assign mix_c = (r_mix > 17'd65536) ? 17'd65536 : r_mix;
    assign dep_c = (r_depth > 17'd65536) ? 17'd65536 : r_depth;
    assign dry_g = 17'(18'd65536 - 18'(mix_c));
    assign pos   = PW'({r_widx, 8'd0}) - PW'(r_delay);
    assign a0    = pos[PW-1:8];
    assign a1    = a0 + AW'(1);

    assign s_axis_tready = !r_clr && r_state == ST_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_READ0;
            ST_READ0:  n_state = ST_READ1;
            ST_READ1:  n_state = ST_INTERP;
            ST_INTERP: n_state = ST_TONE;
            ST_TONE:   n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_OUT;
            ST_OUT:    if (!r_out_v || m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (r_state)
            ST_READ0:  ctl.rd0 = 1'b1;
            ST_READ1:  ctl.rd1 = 1'b1;
            ST_INTERP: ctl.interp = 1'b1;
            ST_TONE:   ctl.tone = 1'b1;
            ST_WRITE: begin
                ctl.wr  = 1'b1;
                ctl.mix = 1'b1;
            end
            default:   ;
        endcase
    end

    assign out_load = r_state == ST_OUT && (!r_out_v || m_axis_tready);

    sfdd_lane #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SB)) u_lane_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_clr(r_clr), .i_clr_addr(r_clr_cnt[AW-1:0]),
        .i_addr0(a0), .i_addr1(a1), .i_waddr(r_widx), .i_frac(pos[7:0]),
        .i_x(r_x[SB-1:0]), .i_tone_coeff(r_tone_c), .i_feedback(r_fb),
        .i_dry_gain(dry_g), .i_wet_gain(wet_g), .o_y(yl)
    );

    sfdd_lane #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SB)) u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_clr(r_clr), .i_clr_addr(r_clr_cnt[AW-1:0]),
        .i_addr0(a0), .i_addr1(a1), .i_waddr(r_widx), .i_frac(pos[7:0]),
        .i_x(r_x[2*SB-1:SB]), .i_tone_coeff(r_tone_c), .i_feedback(r_fb),
        .i_dry_gain(dry_g), .i_wet_gain(wet_g), .o_y(yr)
    );

    sfdd_env #(.SAMPLE_BITS(SB)) u_env (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_peak(ctl.rd0), .i_lvl(ctl.rd1), .i_gain(ctl.interp), .i_wetg(ctl.tone),
        .i_x(r_x[SB-1:0]), .i_sens(r_sens), .i_attack(r_att), .i_release(r_rel),
        .i_depth(dep_c), .i_mix(mix_c), .o_wet_gain(wet_g)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_widx    <= '0;
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r_out_v   <= 1'b0;
            r_delay   <= 25'd4300800;
            r_fb      <= 16'd22938;
            r_tone_c  <= 16'd38824;
            r_mix     <= 17'd22938;
            r_depth   <= 17'd0;
            r_sens    <= 16'd16384;
            r_att     <= 24'd16733583;
            r_rel     <= 24'd16775818;
        end else begin
            r_state <= n_state;
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + (AW+1)'(1);
                if (r_clr_cnt == (AW+1)'(LINE_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (ctl.wr) begin
                r_widx <= r_widx + AW'(1);
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_DELAY_TIME:    r_delay  <= i_cfg_data[24:0];
                    REG_FEEDBACK_GAIN: r_fb     <= i_cfg_data[15:0];
                    REG_TONE_COEFF:    r_tone_c <= i_cfg_data[15:0];
                    REG_WET_MIX:       r_mix    <= i_cfg_data[16:0];
                    REG_DUCK_DEPTH:    r_depth  <= i_cfg_data[16:0];
                    REG_DUCK_SENS:     r_sens   <= i_cfg_data[15:0];
                    REG_ATTACK_COEFF:  r_att    <= i_cfg_data[23:0];
                    REG_RELEASE_COEFF: r_rel    <= i_cfg_data[23:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= s_axis_tdata;
        end
        if (out_load) begin
            r_out <= {yr, yl};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;
endmodule

>>> rtl/sfdd_checker.sv
// Port-level checker for the stereo feedback delay, bound to the top level.
// Depends on stereo_feedback_delay_ducking_unit.
module sfdd_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [2*SAMPLE_BITS-1:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("took two frames in a row");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid))
        else $error("result too early");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("valid out of reset");
endmodule

bind stereo_feedback_delay_ducking_unit sfdd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
